/* src/vdle_pkg.sv */
package vdle_pkg;

  localparam int unsigned MemWordsDef   = 8192;
  localparam int unsigned StackDepthDef = 8;

  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_GO    = 2'd1;
  localparam logic [1:0] ACT_STEP  = 2'd2;
  localparam logic [1:0] ACT_NONE  = 2'd3;

  localparam logic [1:0] DRAW_NONE  = 2'd0;
  localparam logic [1:0] DRAW_POINT = 2'd1;
  localparam logic [1:0] DRAW_LINE  = 2'd2;

  localparam logic [1:0] FAULT_NONE  = 2'd0;
  localparam logic [1:0] FAULT_UNDER = 2'd1;
  localparam logic [1:0] FAULT_OVER  = 2'd2;
  localparam logic [1:0] FAULT_EMPTY = 2'd3;

  localparam logic [2:0] OP_LVEC   = 3'd0;
  localparam logic [2:0] OP_HALT   = 3'd1;
  localparam logic [2:0] OP_SVEC   = 3'd2;
  localparam logic [2:0] OP_STAT   = 3'd3;
  localparam logic [2:0] OP_CENTER = 3'd4;
  localparam logic [2:0] OP_CALL   = 3'd5;
  localparam logic [2:0] OP_RET    = 3'd6;
  localparam logic [2:0] OP_JUMP   = 3'd7;

  localparam logic [31:0] CenterX = 32'd375 << 16;
  localparam logic [31:0] CenterY = 32'd420 << 16;

  typedef struct packed {
    logic [1:0]  action;
    logic [12:0] address;
    logic [15:0] word_data;
  } vdle_in_t;

  typedef struct packed {
    logic [1:0]         draw_kind;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic signed [15:0] end_x;
    logic signed [15:0] end_y;
    logic [7:0]         red_level;
    logic [7:0]         green_level;
    logic [7:0]         blue_level;
    logic               halted;
    logic [1:0]         fault;
    logic [31:0]        draw_cycles;
  } vdle_out_t;

  // memory access request from sequencer
  typedef struct packed {
    logic        we;
    logic [12:0] addr;
    logic [15:0] wdata;
  } vdle_mreq_t;

endpackage

/* src/vector_display_list_engine.sv */
// Vector display list engine.
// Input channel: in_data (action, address, word_data) is taken on a clock
// edge with start high and busy low. Every accepted transaction yields
// exactly one result on out_data, marked by out_valid for one cycle.
// Path from acceptance to the result: write passes through S_WR; ignored
// actions and steps while halted go straight to the result state S_OUT.
// Go reads words 0 and 1 (S_GO0, S_GO1, S_F2). Execute fetches (S_F0, S_F1)
// for one-word instructions, adds a stack read (S_RET) for return, and for
// vectors adds one registered multiply stage per axis (S_MUL) and blend
// (S_BLEND); long vectors first read their second word (S_F2). The sequence
// follows from the single registered read port of the list memory.
// busy is high from acceptance until the result cycle begins, so the next
// transaction can be taken at the edge that ends the result cycle.
// Reset (rst_n low, synchronous) leaves the engine halted, scale 1,
// all positions, colors and totals zero; memory contents stay undefined
// until written. The receiver cannot stall: results are not held.
module vector_display_list_engine import vdle_pkg::*; #(
  parameter int unsigned MEMORY_WORDS = MemWordsDef,
  parameter int unsigned STACK_DEPTH  = StackDepthDef
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  vdle_in_t  in_data,
  output logic      out_valid,
  output vdle_out_t out_data
);
  localparam logic [3:0] SpTop = 4'(STACK_DEPTH - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_WR, S_GO0, S_GO1, S_F0, S_F1, S_F2, S_RET, S_MUL, S_BLEND, S_OUT
  } state_t;

  state_t      state_r;
  vdle_in_t    item_r;
  vdle_mreq_t  mreq;
  logic [15:0] mrdata;
  logic        stk_we;
  logic [3:0]  stk_addr;
  logic [12:0] stk_rdata;

  logic [3:0]  sp_r;
  logic [12:0] pc_r;
  logic [31:0] px_r, py_r;
  logic [17:0] scale_r;
  logic [7:0]  inten_r, red_r, grn_r, blu_r;
  logic        done_r;
  logic [31:0] cyc_r;
  logic [1:0]  fault_r;
  logic [15:0] fw_r;
  logic        w0z_r;
  logic signed [12:0] vx_r, vy_r;
  logic [3:0]  vz_r;
  logic signed [31:0] dx_r, dy_r;
  vdle_out_t   out_r;
  logic        out_valid_r;

  logic [12:0] pc_inc;
  assign pc_inc = pc_r + 13'd1;

  vdle_mem #(.MEMORY_WORDS(MEMORY_WORDS)) u_mem (
    .clk(clk), .req(mreq), .rdata(mrdata)
  );
  // return address pushed is the counter past the call word
  vdle_stack #(.STACK_DEPTH(STACK_DEPTH)) u_stk (
    .clk(clk), .we(stk_we), .addr(stk_addr), .wdata(pc_inc), .rdata(stk_rdata)
  );

  always_comb begin
    mreq = '0;
    mreq.addr = pc_r;
    case (state_r)
      S_IDLE: mreq.addr = pc_r;
      S_WR: begin
        mreq.we = 1'b1;
        mreq.addr = item_r.address;
        mreq.wdata = item_r.word_data;
      end
      S_GO0: mreq.addr = 13'd0;
      S_GO1: mreq.addr = 13'd1;
      // fetch the second word of a long vector
      S_F1: mreq.addr = pc_inc;
      default: mreq.addr = pc_r;
    endcase
  end

  // stack: push on call, read for return
  logic [2:0] op_c;
  logic [3:0] sp_dec;
  assign op_c   = mrdata[15:13];
  assign sp_dec = (sp_r == 4'd0) ? SpTop : sp_r - 4'd1;
  always_comb begin
    stk_we   = 1'b0;
    stk_addr = sp_r;
    if (state_r == S_F1 && op_c == OP_CALL && mrdata[12:0] != 13'd0) begin
      stk_we = 1'b1;
    end else if (state_r == S_F1 && op_c == OP_RET) begin
      stk_addr = sp_dec;
    end
  end

  // scale: ((~level << 16) >> (b + 8)) * 3
  logic [15:0] scl_sh;
  logic [17:0] scl_c;
  assign scl_sh = {~mrdata[7:0], 8'd0} >> mrdata[10:8];
  assign scl_c  = {2'b00, scl_sh} + {1'b0, scl_sh, 1'b0};

  // multiply stage
  logic signed [31:0] mx, my;
  assign mx = 32'(vx_r * $signed({1'b0, scale_r}));
  assign my = 32'(vy_r * $signed({1'b0, scale_r}));

  // blend
  logic [31:0] ax, ay, amax;
  logic [11:0] zprod;
  logic [8:0]  zi, zi1;
  logic [7:0]  zf;
  logic [31:0] nx, ny;
  always_comb begin
    ax = dx_r[31] ? 32'(-dx_r) : dx_r;
    ay = dy_r[31] ? 32'(-dy_r) : dy_r;
    amax = (ax > ay) ? ax : ay;
    zprod = 12'(vz_r * inten_r);
    zi = (zprod[11:3] > 9'd255) ? 9'd255 : zprod[11:3];
    zi1 = zi + 9'd1;
    zf = (zi1 > 9'd255) ? 8'd255 : zi1[7:0];
    nx = px_r + dx_r;
    ny = py_r + dy_r;
  end

  always_ff @(posedge clk) begin
    out_valid_r <= 1'b0;
    if (!rst_n) begin
      state_r <= S_IDLE;
      sp_r <= '0; pc_r <= '0; px_r <= '0; py_r <= '0;
      scale_r <= 18'd1; inten_r <= '0; red_r <= '0; grn_r <= '0; blu_r <= '0;
      done_r <= 1'b1; cyc_r <= '0; fault_r <= FAULT_NONE;
    end else begin
      case (state_r)
        S_IDLE: if (start) begin
          item_r <= in_data;
          out_r <= '0;
          case (in_data.action)
            ACT_WRITE: state_r <= S_WR;
            ACT_GO: state_r <= S_GO0;
            ACT_STEP: state_r <= done_r ? S_OUT : S_F0;
            default: state_r <= S_OUT;
          endcase
        end
        S_WR: state_r <= S_OUT;
        S_GO0: state_r <= S_GO1;
        S_GO1: begin
          w0z_r <= (mrdata == 16'd0);
          state_r <= S_F2;
        end
        S_F0: state_r <= S_F1;
        S_F1: begin
          fw_r <= mrdata;
          pc_r <= pc_inc;
          state_r <= S_OUT;
          case (op_c)
            OP_LVEC: state_r <= S_F2;
            OP_SVEC: begin
              vx_r <= 13'(signed'({mrdata[4:0], 1'b0}));
              vy_r <= 13'(signed'({mrdata[12:8], 1'b0}));
              vz_r <= {mrdata[7:5], 1'b0};
              state_r <= S_MUL;
            end
            OP_STAT: begin
              if (mrdata[12]) begin
                scale_r <= scl_c;
              end else begin
                blu_r <= {5'd0, mrdata[10], 2'd0};
                grn_r <= {6'd0, mrdata[9], 1'd0};
                red_r <= {7'd0, mrdata[8]};
                inten_r <= mrdata[7:0];
              end
            end
            OP_CENTER: begin
              px_r <= CenterX; py_r <= CenterY;
            end
            OP_RET: begin
              if (sp_r == 4'd0) begin
                done_r <= 1'b1; fault_r <= FAULT_UNDER;
              end
              sp_r <= sp_dec;
              state_r <= S_RET;
            end
            OP_JUMP: begin
              if (mrdata[12:0] == 13'd0) done_r <= 1'b1;
              else pc_r <= mrdata[12:0];
            end
            OP_CALL: begin
              if (mrdata[12:0] == 13'd0) done_r <= 1'b1;
              else begin
                if (sp_r >= SpTop) begin
                  done_r <= 1'b1; fault_r <= FAULT_OVER; sp_r <= '0;
                end else sp_r <= sp_r + 4'd1;
                pc_r <= mrdata[12:0];
              end
            end
            default: done_r <= 1'b1;
          endcase
        end
        S_F2: begin
          if (item_r.action == ACT_GO) begin
            sp_r <= '0; pc_r <= '0; px_r <= '0; py_r <= '0; scale_r <= 18'd1;
            inten_r <= '0; red_r <= '0; grn_r <= '0; blu_r <= '0;
            cyc_r <= 32'd8;
            if (w0z_r && mrdata == 16'd0) begin
              done_r <= 1'b1; fault_r <= FAULT_EMPTY;
            end else begin
              done_r <= 1'b0; fault_r <= FAULT_NONE;
            end
            state_r <= S_OUT;
          end else begin
            pc_r <= pc_inc;
            vx_r <= signed'(mrdata[12:0]);
            vy_r <= signed'(fw_r[12:0]);
            vz_r <= {mrdata[15:13], 1'b0};
            state_r <= S_MUL;
          end
        end
        S_RET: begin
          pc_r <= stk_rdata;
          state_r <= S_OUT;
        end
        S_MUL: begin
          dx_r <= mx; dy_r <= my;
          state_r <= S_BLEND;
        end
        S_BLEND: begin
          if (zi != 9'd0) begin
            if (red_r != 8'd0) red_r <= zf;
            if (grn_r != 8'd0) grn_r <= zf;
            if (blu_r != 8'd0) blu_r <= zf;
            out_r.start_x <= px_r[31:16];
            out_r.start_y <= py_r[31:16];
            out_r.red_level <= (red_r != 8'd0) ? zf : 8'd0;
            out_r.green_level <= (grn_r != 8'd0) ? zf : 8'd0;
            out_r.blue_level <= (blu_r != 8'd0) ? zf : 8'd0;
            if (dx_r == 32'd0 && dy_r == 32'd0) begin
              out_r.draw_kind <= DRAW_POINT;
              out_r.end_x <= px_r[31:16];
              out_r.end_y <= py_r[31:16];
            end else begin
              out_r.draw_kind <= DRAW_LINE;
              out_r.end_x <= nx[31:16];
              out_r.end_y <= ny[31:16];
            end
          end
          px_r <= nx; py_r <= ny;
          cyc_r <= cyc_r + 32'(amax >> 17);
          state_r <= S_OUT;
        end
        S_OUT: begin
          out_valid_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  always_comb begin
    out_data = out_r;
    out_data.halted = done_r;
    out_data.fault = fault_r;
    out_data.draw_cycles = cyc_r;
  end

`ifndef SYNTHESIS
  a_idle_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accept did not raise busy");
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result repeated");
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result while busy");
  a_sp_range: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SpTop) else $error("stack pointer out of range");
`endif
endmodule

/* src/vdle_mem.sv */
module vdle_mem import vdle_pkg::*; #(
  parameter int unsigned MEMORY_WORDS = MemWordsDef
) (
  input  logic       clk,
  input  vdle_mreq_t req,
  output logic [15:0] rdata
);
  localparam int unsigned AW = (MEMORY_WORDS > 1) ? $clog2(MEMORY_WORDS) : 1;

  logic [15:0] mem [MEMORY_WORDS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr[AW-1:0]] <= req.wdata;
    end
    rdata <= mem[req.addr[AW-1:0]];
  end
endmodule

/* src/vdle_stack.sv */
module vdle_stack import vdle_pkg::*; #(
  parameter int unsigned STACK_DEPTH = StackDepthDef
) (
  input  logic        clk,
  input  logic        we,
  input  logic [3:0]  addr,
  input  logic [12:0] wdata,
  output logic [12:0] rdata
);
  localparam int unsigned SW = $clog2(STACK_DEPTH);

  logic [12:0] stk [STACK_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      stk[addr[SW-1:0]] <= wdata;
    end
    rdata <= stk[addr[SW-1:0]];
  end
endmodule
